@@ sv/wsfp_pkg.sv @@
`default_nettype none

package wsfp_pkg;

    localparam int CHUNK_BYTES = 16384;
    localparam int POS_W       = $clog2(CHUNK_BYTES);
    localparam int LEN_W       = 64;
    localparam int KEY_W       = 32;
    localparam int HDR_W       = 4;

    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_PING  = 2'd2;
    localparam logic [1:0] KIND_PONG  = 2'd3;

    localparam logic [1:0] FS_COMPLETE   = 2'd0;
    localparam logic [1:0] FS_INCOMPLETE = 2'd1;
    localparam logic [1:0] FS_EMPTY      = 2'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [HDR_W-1:0] EXT16_BYTES = HDR_W'(2);
    localparam logic [HDR_W-1:0] EXT64_BYTES = HDR_W'(8);
    localparam logic [HDR_W-1:0] KEY_BYTES   = HDR_W'(4);

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_LEN7,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_chunk;
    } t_in_item;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_status;
        logic [1:0] frame_kind;
        logic [3:0] frame_opcode;
        logic [1:0] frame_status;
        logic       close_seen;
        logic       last;
    } t_out_item;

    function automatic logic [1:0] kind_of(input logic [3:0] op);
        logic [1:0] k;
        case (op)
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            OP_PONG:  k = KIND_PONG;
            default:  k = KIND_DATA;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ sv/websocket_frame_parser_unit.sv @@
`default_nettype none
// results: an accepted item is held in the input register, then its results are
// queued; a status item after a payload byte of the same item is offered behind it
// throughput: one byte item per cycle while the result queue has room; a chunk end
// that also carries a payload byte yields two results for the single output port
// reset: synchronous active-low reset clears parser state, input register and queue;
// the parser also returns to its reset state after each chunk's status item
module websocket_frame_parser_unit import wsfp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    // input register
    logic      r_in_valid;
    t_in_item  r_in;

    // parser state
    t_phase             r_phase,    n_phase;
    logic [3:0]         r_opcode,   n_opcode;
    logic               r_mask,     n_mask;
    logic [LEN_W-1:0]   r_len,      n_len;
    logic [HDR_W-1:0]   r_hdr,      n_hdr;
    logic [KEY_W-1:0]   r_key,      n_key;
    logic [POS_W-1:0]   r_pld_cnt,  n_pld_cnt;
    logic [POS_W-1:0]   r_pos,      n_pos;
    logic               r_ext_long, n_ext_long;

    // result queue
    t_out_item  r_q [2];
    t_out_item  n_q [2];
    logic [1:0] r_cnt, n_cnt;

    logic       eoc;
    logic       pld_emit;
    logic [7:0] pld_val;
    logic [1:0] n_res;
    t_out_item  res_a, res_b;
    logic       pop;
    logic [1:0] base;
    logic       fire;
    logic [LEN_W-1:0] cnt_next_ext;

    assign eoc = r_in.end_of_chunk || (r_pos >= POS_W'(CHUNK_BYTES - 1));
    assign cnt_next_ext = LEN_W'({1'b0, r_pld_cnt} + (POS_W + 1)'(1));

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_mask     = r_mask;
        n_len      = r_len;
        n_hdr      = r_hdr;
        n_key      = r_key;
        n_pld_cnt  = r_pld_cnt;
        n_ext_long = r_ext_long;
        pld_emit   = 1'b0;
        pld_val    = r_in.rx_byte;
        case (r_phase)
            PH_OPCODE: begin
                n_opcode = r_in.rx_byte[3:0];
                n_phase  = PH_LEN7;
            end
            PH_LEN7: begin
                n_mask = r_in.rx_byte[7];
                n_len  = '0;
                n_hdr  = '0;
                if (r_in.rx_byte[6:0] == LEN7_EXT16) begin
                    n_ext_long = 1'b0;
                    n_phase    = PH_EXTLEN;
                end else if (r_in.rx_byte[6:0] == LEN7_EXT64) begin
                    n_ext_long = 1'b1;
                    n_phase    = PH_EXTLEN;
                end else begin
                    n_len = LEN_W'(r_in.rx_byte[6:0]);
                    if (r_in.rx_byte[7]) begin
                        n_phase = PH_KEY;
                    end else if (r_in.rx_byte[6:0] == 7'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[LEN_W-9:0], r_in.rx_byte};
                n_hdr = r_hdr + HDR_W'(1);
                if (n_hdr >= (r_ext_long ? EXT64_BYTES : EXT16_BYTES)) begin
                    n_hdr = '0;
                    if (r_mask) begin
                        n_phase = PH_KEY;
                    end else if (n_len == '0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                n_key = {r_key[KEY_W-9:0], r_in.rx_byte};
                n_hdr = r_hdr + HDR_W'(1);
                if (n_hdr >= KEY_BYTES) begin
                    n_hdr   = '0;
                    n_phase = (r_len == '0) ? PH_DONE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pld_emit = 1'b1;
                if (r_mask) begin
                    case (r_pld_cnt[1:0])
                        2'd0:    pld_val = r_in.rx_byte ^ r_key[31:24];
                        2'd1:    pld_val = r_in.rx_byte ^ r_key[23:16];
                        2'd2:    pld_val = r_in.rx_byte ^ r_key[15:8];
                        default: pld_val = r_in.rx_byte ^ r_key[7:0];
                    endcase
                end
                n_pld_cnt = r_pld_cnt + POS_W'(1);
                if (cnt_next_ext >= r_len) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        n_pos = r_pos + POS_W'(1);
    end

    // results of the item in the input register
    always_comb begin
        t_out_item pld_item;
        t_out_item st_item;
        logic      done;
        done = (n_phase == PH_DONE);

        pld_item.payload_byte = pld_val;
        pld_item.is_status    = 1'b0;
        pld_item.frame_kind   = kind_of(r_opcode);
        pld_item.frame_opcode = r_opcode;
        pld_item.frame_status = FS_COMPLETE;
        pld_item.close_seen   = 1'b0;
        pld_item.last         = 1'b0;

        st_item.payload_byte = 8'd0;
        st_item.is_status    = 1'b1;
        st_item.frame_kind   = kind_of(n_opcode);
        st_item.frame_opcode = n_opcode;
        if (!done) begin
            st_item.frame_status = FS_INCOMPLETE;
        end else if (kind_of(n_opcode) == KIND_DATA && n_len == '0) begin
            st_item.frame_status = FS_EMPTY;
        end else begin
            st_item.frame_status = FS_COMPLETE;
        end
        st_item.close_seen = done && (n_opcode == OP_CLOSE);
        st_item.last       = 1'b1;

        n_res = {1'b0, pld_emit} + {1'b0, eoc};
        res_a = pld_emit ? pld_item : st_item;
        res_b = st_item;
    end

    // result queue and handshakes
    assign pop         = (r_cnt != 2'd0) && i_out_ready;
    assign base        = r_cnt - {1'b0, pop};
    assign fire        = r_in_valid && (({1'b0, base} + {1'b0, n_res}) <= 3'd2);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_q[0];

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = base;
        if (fire) begin
            n_cnt = base + n_res;
            case (base)
                2'd0: begin
                    if (n_res != 2'd0) begin
                        n_q[0] = res_a;
                    end
                    if (n_res == 2'd2) begin
                        n_q[1] = res_b;
                    end
                end
                2'd1: begin
                    if (n_res != 2'd0) begin
                        n_q[1] = res_a;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && eoc)) begin
            r_phase    <= PH_OPCODE;
            r_opcode   <= '0;
            r_mask     <= 1'b0;
            r_len      <= '0;
            r_hdr      <= '0;
            r_key      <= '0;
            r_pld_cnt  <= '0;
            r_pos      <= '0;
            r_ext_long <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_opcode   <= n_opcode;
            r_mask     <= n_mask;
            r_len      <= n_len;
            r_hdr      <= n_hdr;
            r_key      <= n_key;
            r_pld_cnt  <= n_pld_cnt;
            r_pos      <= n_pos;
            r_ext_long <= n_ext_long;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overfilled");

    a_chunk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && eoc |=> r_phase == PH_OPCODE && r_pos == '0 && r_pld_cnt == '0)
        else $error("parser not restarted after chunk end");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("waiting item lost from input register");

    a_pld_behind_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pld_cnt <= r_pos)
        else $error("payload count ahead of chunk position");

endmodule

`default_nettype wire

@@ dv/websocket_frame_parser_unit_tb.sv @@
module websocket_frame_parser_unit_tb;
    import wsfp_pkg::*;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam int        RUN_LIMIT   = 60000;
    localparam int        PHASE_BYTES = 470;
    localparam int        EXP_DEPTH   = 1024;
    localparam t_out_item NO_RESULT   = '0;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    websocket_frame_parser_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // frame parser state
    t_phase      rx_phase;
    logic [3:0]  hdr_op;
    logic        key_on;
    logic [63:0] frame_len;
    logic [3:0]  hdr_bytes;
    logic [3:0]  len_bytes;
    logic [31:0] key_word;
    logic [14:0] pay_idx;
    int          byte_pos;

    t_out_item   exp_ring [EXP_DEPTH];
    int          exp_wr    = 0;
    int          exp_rd    = 0;
    logic [7:0]  chunk_bytes [256];
    int          chunk_len = 0;
    t_dir_row    dir_rows [23];

    int n_bytes     = 0;
    int n_results   = 0;
    int n_status    = 0;
    int n_errors    = 0;
    int cycle_cnt   = 0;
    int rx_cycles   = 0;
    int tx_idle_pct = 11;
    int rx_idle_pct = 64;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic exp_add(input t_out_item r);
        exp_ring[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    task automatic chunk_add(input logic [7:0] b);
        chunk_bytes[chunk_len] = b;
        chunk_len++;
    endtask

    task automatic restart_parser();
        rx_phase  = PH_OPCODE;
        hdr_op    = '0;
        key_on    = 1'b0;
        frame_len = '0;
        hdr_bytes = '0;
        len_bytes = '0;
        key_word  = '0;
        pay_idx   = '0;
        byte_pos  = 0;
    endtask

    task automatic header_done();
        hdr_bytes = '0;
        if (key_on) begin
            rx_phase = PH_KEY;
        end else if (frame_len == 0) begin
            rx_phase = PH_DONE;
        end else begin
            rx_phase = PH_PAYLOAD;
        end
    endtask

    function automatic logic [1:0] kind_for(input logic [3:0] op);
        case (op)
            OP_CLOSE: return KIND_CLOSE;
            OP_PING:  return KIND_PING;
            OP_PONG:  return KIND_PONG;
            default:  return KIND_DATA;
        endcase
    endfunction

    function automatic t_out_item make_result(input logic [7:0] pb, input logic st,
                                              input logic [1:0] fs, input logic cs);
        t_out_item r;
        r.payload_byte = pb;
        r.is_status    = st;
        r.frame_kind   = kind_for(hdr_op);
        r.frame_opcode = hdr_op;
        r.frame_status = fs;
        r.close_seen   = cs;
        r.last         = st;
        return r;
    endfunction

    function automatic t_out_item status_of(input logic [1:0] kind, input logic [3:0] op,
                                            input logic [1:0] fs, input logic cs);
        return {8'h00, 1'b1, kind, op, fs, cs, 1'b1};
    endfunction

    task automatic deframe_byte(input t_in_item it, output int n, output t_out_item r0,
                                output t_out_item r1);
        logic       eoc;
        logic [7:0] v;
        logic [1:0] fs;
        t_out_item  st;
        n   = 0;
        r0  = NO_RESULT;
        r1  = NO_RESULT;
        eoc = it.end_of_chunk || byte_pos >= CHUNK_BYTES - 1;
        case (rx_phase)
            PH_OPCODE: begin
                hdr_op   = it.rx_byte[3:0];
                rx_phase = PH_LEN7;
            end
            PH_LEN7: begin
                key_on    = it.rx_byte[7];
                frame_len = '0;
                hdr_bytes = '0;
                if (it.rx_byte[6:0] == LEN7_EXT16) begin
                    len_bytes = EXT16_BYTES;
                    rx_phase  = PH_EXTLEN;
                end else if (it.rx_byte[6:0] == LEN7_EXT64) begin
                    len_bytes = EXT64_BYTES;
                    rx_phase  = PH_EXTLEN;
                end else begin
                    frame_len = 64'(it.rx_byte[6:0]);
                    header_done();
                end
            end
            PH_EXTLEN: begin
                frame_len = {frame_len[55:0], it.rx_byte};
                hdr_bytes++;
                if (hdr_bytes >= len_bytes) header_done();
            end
            PH_KEY: begin
                key_word = {key_word[23:0], it.rx_byte};
                hdr_bytes++;
                if (hdr_bytes >= KEY_BYTES) begin
                    hdr_bytes = '0;
                    rx_phase  = (frame_len == 0) ? PH_DONE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                v = it.rx_byte;
                if (key_on) v ^= key_word[31 - 8 * pay_idx[1:0] -: 8];
                r0 = make_result(v, 1'b0, FS_COMPLETE, 1'b0);
                n  = 1;
                pay_idx++;
                if (64'(pay_idx) >= frame_len) rx_phase = PH_DONE;
            end
            default: ;
        endcase
        byte_pos++;
        if (eoc) begin
            if (rx_phase != PH_DONE) begin
                fs = FS_INCOMPLETE;
            end else if (kind_for(hdr_op) == KIND_DATA && frame_len == 0) begin
                fs = FS_EMPTY;
            end else begin
                fs = FS_COMPLETE;
            end
            st = make_result(8'h00, 1'b1, fs, rx_phase == PH_DONE && hdr_op == OP_CLOSE);
            if (n == 0) begin
                r0 = st;
            end else begin
                r1 = st;
            end
            n++;
            restart_parser();
        end
    endtask

    task automatic send_byte(input t_in_item it, input logic typed, input t_out_item want);
        int        n;
        t_out_item r0;
        t_out_item r1;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        n_bytes++;
        deframe_byte(it, n, r0, r1);
        if (typed) r0 = want;
        if (n >= 1) exp_add(r0);
        if (n == 2) exp_add(r1);
    endtask

    task automatic send_chunk();
        for (int i = 0; i < chunk_len; i++) begin
            send_byte({chunk_bytes[i], i == chunk_len - 1}, 1'b0, NO_RESULT);
        end
        chunk_len = 0;
    endtask

    // big-endian, as on the wire
    task automatic add_bytes(input logic [63:0] value, input int count);
        for (int i = count - 1; i >= 0; i--) chunk_add(value[8*i +: 8]);
    endtask

    task automatic build_chunk();
        logic [3:0]  op;
        logic        msk;
        logic [63:0] dlen;
        int          form;
        int          body;
        form = $urandom_range(99);
        if (form < 8) begin
            // noise chunk
            repeat ($urandom_range(1, 6)) chunk_add(8'($urandom));
            return;
        end
        case ($urandom_range(7))
            0:       op = 4'h0;
            1:       op = 4'h1;
            2:       op = 4'h2;
            3:       op = OP_CLOSE;
            4:       op = OP_PING;
            5:       op = OP_PONG;
            default: op = 4'($urandom_range(15));
        endcase
        msk = 1'($urandom_range(1));
        chunk_add({4'($urandom_range(15)), op});
        if (form < 70) begin
            if (form < 14) begin
                dlen = '0;
            end else if ($urandom_range(9) == 0) begin
                dlen = 64'($urandom_range(13, 125));
            end else begin
                dlen = 64'($urandom_range(1, 12));
            end
            chunk_add({msk, 7'(dlen)});
        end else if (form < 85) begin
            case ($urandom_range(5))
                0:       dlen = 64'($urandom_range(65535));
                1:       dlen = 64'($urandom_range(126, 200));
                default: dlen = 64'($urandom_range(0, 20));
            endcase
            chunk_add({msk, LEN7_EXT16});
            add_bytes(dlen, 2);
        end else begin
            dlen = ($urandom_range(2) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 20));
            chunk_add({msk, LEN7_EXT64});
            add_bytes(dlen, 8);
        end
        if (msk) add_bytes(64'($urandom), 4);
        body = (dlen <= 200) ? int'(dlen) : int'($urandom_range(0, 8));
        repeat (body) chunk_add(8'($urandom));
        if ($urandom_range(9) == 0) begin
            // cut short
            chunk_len = chunk_len - int'($urandom_range(1, chunk_len - 1));
        end else begin
            repeat ($urandom_range(0, 3)) chunk_add(8'($urandom));
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin : rx_side
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (exp_wr == exp_rd) begin
                $display("%0t: result expected none, got %h", $time, out_item);
                n_errors++;
            end else begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("payload_byte", want.payload_byte, out_item.payload_byte);
                check_field("is_status", 8'(want.is_status), 8'(out_item.is_status));
                check_field("frame_kind", 8'(want.frame_kind), 8'(out_item.frame_kind));
                check_field("frame_opcode", 8'(want.frame_opcode),
                            8'(out_item.frame_opcode));
                check_field("frame_status", 8'(want.frame_status),
                            8'(out_item.frame_status));
                check_field("close_seen", 8'(want.close_seen), 8'(out_item.close_seen));
                check_field("last", 8'(want.last), 8'(out_item.last));
                if (out_item.is_status) n_status++;
            end
        end
        rx_cycles++;
        // long hold-off so the block backs up into its input
        if (rx_cycles >= 300 && rx_cycles < 700) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int stop_at;
        restart_parser();
        dir_rows = '{
            {8'h81, 1'b1, 1'b1, status_of(KIND_DATA, 4'h1, FS_INCOMPLETE, 1'b0)},
            {8'h82, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b1, 1'b1, status_of(KIND_DATA, 4'h2, FS_EMPTY, 1'b0)},
            {8'h88, 1'b0, 1'b0, NO_RESULT},
            {8'h80, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b0, NO_RESULT},
            {8'hA5, 1'b0, 1'b0, NO_RESULT},
            {8'h5A, 1'b1, 1'b1, status_of(KIND_CLOSE, OP_CLOSE, FS_COMPLETE, 1'b1)},
            {8'h89, 1'b0, 1'b0, NO_RESULT},
            {8'h82, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b0, NO_RESULT},
            {8'hA5, 1'b0, 1'b0, NO_RESULT},
            {8'h5A, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b1, 1'b0, NO_RESULT},
            {8'h0A, 1'b0, 1'b0, NO_RESULT},
            {8'h7E, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b0, NO_RESULT},
            {8'h01, 1'b0, 1'b0, NO_RESULT},
            {8'h33, 1'b0, 1'b0, NO_RESULT},
            {8'hEE, 1'b1, 1'b1, status_of(KIND_PONG, OP_PONG, FS_COMPLETE, 1'b0)}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 64 : 0;
            rx_idle_pct = (p == 0) ? 64 : (p == 1) ? 11 : 0;
            if (p == 0) begin
                foreach (dir_rows[i]) begin
                    send_byte(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
                end
            end
            stop_at = n_bytes + PHASE_BYTES;
            while (n_bytes < stop_at) begin
                build_chunk();
                send_chunk();
            end
        end
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d bytes sent over %0d chunks: short, empty, masked, extended-length,",
                 n_bytes, n_status);
        $display("truncated and noise chunks; %0d results compared", n_results);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/wsfp_pkg.sv
sv/websocket_frame_parser_unit.sv
dv/websocket_frame_parser_unit_tb.sv
